/* rtl/fdhp_pkg.sv */
package fdhp_pkg;

  localparam int unsigned TempW   = 19;
  localparam int unsigned DutyW   = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = $clog2(NumRegs);
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 16;

  typedef logic signed [TempW-1:0] temp_t;
  typedef logic [DutyW-1:0]        duty_t;

  localparam duty_t DutyMin = 7'd30;
  localparam duty_t DutyMid = 7'd60;
  localparam duty_t DutyMax = 7'd100;

  localparam temp_t XcvrUpLimit   = 19'sd70000;
  localparam temp_t XcvrDownLimit = 19'sd65000;

  typedef enum logic [RegIdxW-1:0] {
    REG_CPU_IDLE    = 3'd0,
    REG_CPU_UP      = 3'd1,
    REG_CPU_DOWN    = 3'd2,
    REG_CPU_PROTECT = 3'd3,
    REG_MAC_IDLE    = 3'd4,
    REG_MAC_UP      = 3'd5,
    REG_MAC_DOWN    = 3'd6,
    REG_MAC_PROTECT = 3'd7
  } reg_idx_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_NORMAL     = 2'd0,
    STATUS_FAN_FAULT  = 2'd1,
    STATUS_SENSOR_ERR = 2'd2
  } status_e;

  localparam temp_t LimitReset [NumRegs] = '{
    19'sd60000, 19'sd85000, 19'sd75000, 19'sd100000,
    19'sd60000, 19'sd90000, 19'sd80000, 19'sd105000
  };

endpackage

/* rtl/fan_duty_hysteresis_policy.sv */
// Three-level fan duty policy with hysteresis.
// Slave stream: one word per evaluation tick carrying fan and sensor health,
// the CPU, MAC and hottest transceiver temperatures and transceiver presence.
// Master stream: one word per tick with the new duty (30, 60 or 100 percent),
// the over-temperature request and the evaluation status.
// The user must write limits through the cfg port only while the block is idle;
// the block itself does not enforce this. Each write takes effect at the next clock edge.
// A word is registered on entry and its result is computed into the output
// register once that register is empty or being read by the receiver. One
// word is accepted per cycle while the receiver keeps up; the held duty
// register is the only loop.
// When the receiver stalls, the result is held and the entry register still
// takes one more word; s_axis_tready falls only when both stages are full.
// Reset clears both stages, sets the duty to 60 percent and loads the
// default limits.
module fan_duty_hysteresis_policy (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // fans_healthy, sensors_read_ok, cpu_mdeg, mac_mdeg, xcvr_mdeg, xcvr_present
  input  logic [fdhp_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // duty_percent, over_temp, eval_status
  output logic [fdhp_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [fdhp_pkg::RegIdxW-1:0]  cfg_idx_i,
  input  logic [fdhp_pkg::TempW-1:0]    cfg_data_i
);
  import fdhp_pkg::*;

  temp_t lim_q [NumRegs];

  logic    in_vld_q;
  logic    fans_ok_q, reads_ok_q, present_q;
  temp_t   cpu_q, mac_q, xcvr_q;

  logic    out_vld_q;
  duty_t   duty_q, duty_d;
  duty_t   out_duty_q;
  logic    out_hot_q, hot_d;
  status_e out_status_q, status_d;

  logic    out_move;
  logic    in_move;

  assign out_move      = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || out_move;
  assign in_move       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        lim_q[i] <= LimitReset[i];
      end
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CPU_IDLE:    lim_q[REG_CPU_IDLE]    <= cfg_data_i;
        REG_CPU_UP:      lim_q[REG_CPU_UP]      <= cfg_data_i;
        REG_CPU_DOWN:    lim_q[REG_CPU_DOWN]    <= cfg_data_i;
        REG_CPU_PROTECT: lim_q[REG_CPU_PROTECT] <= cfg_data_i;
        REG_MAC_IDLE:    lim_q[REG_MAC_IDLE]    <= cfg_data_i;
        REG_MAC_UP:      lim_q[REG_MAC_UP]      <= cfg_data_i;
        REG_MAC_DOWN:    lim_q[REG_MAC_DOWN]    <= cfg_data_i;
        REG_MAC_PROTECT: lim_q[REG_MAC_PROTECT] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_move) begin
      fans_ok_q  <= s_axis_tdata[0];
      reads_ok_q <= s_axis_tdata[1];
      cpu_q      <= s_axis_tdata[20:2];
      mac_q      <= s_axis_tdata[39:21];
      xcvr_q     <= s_axis_tdata[58:40];
      present_q  <= s_axis_tdata[59];
    end
  end

  always_comb begin
    duty_d   = duty_q;
    hot_d    = 1'b0;
    status_d = STATUS_NORMAL;
    if (!fans_ok_q) begin
      duty_d   = DutyMax;
      status_d = STATUS_FAN_FAULT;
    end else if (!reads_ok_q) begin
      duty_d   = DutyMax;
      status_d = STATUS_SENSOR_ERR;
    end else begin
      if (!present_q && (cpu_q < lim_q[REG_CPU_IDLE]) && (mac_q < lim_q[REG_MAC_IDLE])) begin
        duty_d = DutyMin;
      end else if ((cpu_q > lim_q[REG_CPU_UP]) || (mac_q > lim_q[REG_MAC_UP]) ||
                   (xcvr_q > XcvrUpLimit)) begin
        duty_d = DutyMax;
      end else if ((cpu_q < lim_q[REG_CPU_DOWN]) && (mac_q < lim_q[REG_MAC_DOWN]) &&
                   (xcvr_q < XcvrDownLimit)) begin
        duty_d = DutyMid;
      end
      hot_d = (cpu_q > lim_q[REG_CPU_PROTECT]) || (mac_q > lim_q[REG_MAC_PROTECT]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      duty_q    <= DutyMid;
    end else begin
      if (out_move) begin
        out_vld_q <= 1'b1;
        duty_q    <= duty_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_move) begin
      out_duty_q   <= duty_d;
      out_hot_q    <= hot_d;
      out_status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_status_q, out_hot_q, out_duty_q};

`ifndef SYNTHESIS
  a_duty_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty_q == DutyMin) || (duty_q == DutyMid) || (duty_q == DutyMax))
    else $error("held duty is not a valid level");

  a_out_matches_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_duty_q == duty_q))
    else $error("result duty differs from held duty");

  a_fault_forces_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_status_q != STATUS_NORMAL)) |-> (out_duty_q == DutyMax && !out_hot_q))
    else $error("fault result without forced maximum duty");

  a_stall_holds_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready) |=> in_vld_q)
    else $error("entry word lost while output stalled");
`endif

endmodule
